@@ rtl/ihex_pkg.sv @@
// Shared constants, record command type and helper functions for the HEX encoder.
package ihex_pkg;

	// Data bytes per full data record.
	localparam int RecordBytes = 16;
	// Command payload holds at least the four bytes of a start address record.
	localparam int CmdBytes = (RecordBytes > 4) ? RecordBytes : 4;

	localparam int FillW = $clog2(RecordBytes + 1);
	localparam int BufIdxW = (RecordBytes > 1) ? $clog2(RecordBytes) : 1;
	localparam int LenW = $clog2(CmdBytes + 1);
	localparam int CmdIdxW = $clog2(CmdBytes);
	// Byte positions in a record: length, offset high, offset low, type, data, checksum.
	localparam int ByteIdxW = $clog2(CmdBytes + 6);

	localparam int PosLen = 0;
	localparam int PosOffHi = 1;
	localparam int PosOffLo = 2;
	localparam int PosType = 3;
	localparam int PosData = 4;

	// Input operation codes.
	localparam logic [1:0] OpBegin = 2'd0;
	localparam logic [1:0] OpData = 2'd1;
	localparam logic [1:0] OpFinish = 2'd2;

	// Record type codes.
	localparam logic [7:0] RecData = 8'h00;
	localparam logic [7:0] RecEof = 8'h01;
	localparam logic [7:0] RecExtLinear = 8'h04;
	localparam logic [7:0] RecStartLinear = 8'h05;

	localparam logic [6:0] CharColon = 7'h3A;
	localparam logic [6:0] CharNewline = 7'h0A;

	// One record to be printed by the back end.
	typedef struct packed {
		logic [LenW-1:0]             len;
		logic [15:0]                 offset;
		logic [7:0]                  rtype;
		logic [CmdBytes-1:0][7:0]    data;
		logic [7:0]                  checksum;
		logic                        last_rec;
		logic                        eof_follow;
	} ihex_cmd_t;

	// Two's complement checksum over length, offset, type and data sum.
	function automatic logic [7:0] record_checksum(input logic [7:0] len,
			input logic [15:0] offset, input logic [7:0] rtype, input logic [7:0] dsum);
		logic [7:0] sum;
		begin
			sum = len + offset[15:8] + offset[7:0] + rtype + dsum;
			record_checksum = 8'h00 - sum;
		end
	endfunction

	// Uppercase ASCII hex digit for one nibble.
	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		begin
			if (nib < 4'd10) begin
				hex_char = 7'h30 + {3'b000, nib};
			end else begin
				hex_char = 7'h37 + {3'b000, nib};
			end
		end
	endfunction

endpackage

@@ rtl/intel_hex_record_encoder.sv @@
// Intel HEX encoder: one ASCII character per output transfer.
// The first character of a record is offered after the record passes the command queue and
// the current-record register, when the character sequencer is idle.
// The sequencer prints a colon, two hex digits per record byte and a line feed;
// the front end keeps taking input items while the command queue is not full.
// Reset (arst_n low) empties the queue and clears fill count and offsets.
module intel_hex_record_encoder (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   op,
	input  logic [31:0]  address,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [6:0]   out_char,
	output logic         last_char
);

	ihex_pkg::ihex_cmd_t  push_cmd;
	ihex_pkg::ihex_cmd_t  head_cmd;
	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_empty;

	// Item intake and record classification.
	ihex_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.address   (address),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	// Command queue.
	ihex_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head_cmd)
	);

	// Character output.
	ihex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

@@ rtl/ihex_front.sv @@
// Front end: accepts input items, buffers data bytes and issues record commands.
module ihex_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            op,
	input  logic [31:0]           address,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic                  q_full,
	output logic                  q_push,
	output ihex_pkg::ihex_cmd_t   q_cmd
);

	logic [7:0]                   buf_q [ihex_pkg::RecordBytes];
	logic [ihex_pkg::FillW-1:0]   fill_q;
	logic [15:0]                  running_q;
	logic [15:0]                  rec_off_q;
	logic [7:0]                   dsum_q;

	logic                         accept;
	logic [ihex_pkg::FillW-1:0]   new_fill;
	logic [7:0]                   new_dsum;
	logic [15:0]                  rec_off_eff;
	logic                         flush;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	// Record offset is taken from the running offset when the buffer is empty.
	assign rec_off_eff = (fill_q == '0) ? running_q : rec_off_q;
	assign new_fill = fill_q + ihex_pkg::FillW'(1);
	assign new_dsum = dsum_q + data_byte;
	assign flush = (new_fill == ihex_pkg::FillW'(ihex_pkg::RecordBytes)) || last_byte;

	// Build the command for the current item.
	always_comb begin
		q_cmd = '0;
		q_push = 1'b0;
		case (op)
			ihex_pkg::OpBegin: begin
				q_push = accept;
				q_cmd.len = ihex_pkg::LenW'(2);
				q_cmd.rtype = ihex_pkg::RecExtLinear;
				q_cmd.data[0] = address[31:24];
				q_cmd.data[1] = address[23:16];
				q_cmd.checksum = ihex_pkg::record_checksum(8'd2, 16'h0000,
					ihex_pkg::RecExtLinear, address[31:24] + address[23:16]);
				q_cmd.last_rec = 1'b1;
			end
			ihex_pkg::OpData: begin
				q_push = accept && flush;
				q_cmd.len = ihex_pkg::LenW'(new_fill);
				q_cmd.offset = rec_off_eff;
				q_cmd.rtype = ihex_pkg::RecData;
				for (int i = 0; i < ihex_pkg::RecordBytes; i++) begin
					if (fill_q == ihex_pkg::FillW'(i)) begin
						q_cmd.data[i] = data_byte;
					end else begin
						q_cmd.data[i] = buf_q[i];
					end
				end
				q_cmd.checksum = ihex_pkg::record_checksum(8'(new_fill), rec_off_eff,
					ihex_pkg::RecData, new_dsum);
				q_cmd.last_rec = 1'b1;
			end
			ihex_pkg::OpFinish: begin
				q_push = accept;
				q_cmd.len = ihex_pkg::LenW'(4);
				q_cmd.rtype = ihex_pkg::RecStartLinear;
				q_cmd.data[0] = address[31:24];
				q_cmd.data[1] = address[23:16];
				q_cmd.data[2] = address[15:8];
				q_cmd.data[3] = address[7:0];
				q_cmd.checksum = ihex_pkg::record_checksum(8'd4, 16'h0000,
					ihex_pkg::RecStartLinear,
					address[31:24] + address[23:16] + address[15:8] + address[7:0]);
				q_cmd.eof_follow = 1'b1;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// Byte buffer, written at the fill position.
	always_ff @(posedge clk) begin
		if (accept && (op == ihex_pkg::OpData) && !flush) begin
			buf_q[fill_q[ihex_pkg::BufIdxW-1:0]] <= data_byte;
		end
	end

	// Segment bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			running_q <= '0;
			rec_off_q <= '0;
			dsum_q <= '0;
		end else if (accept) begin
			case (op)
				ihex_pkg::OpBegin: begin
					running_q <= address[15:0];
					rec_off_q <= address[15:0];
					fill_q <= '0;
					dsum_q <= '0;
				end
				ihex_pkg::OpData: begin
					if (flush) begin
						running_q <= rec_off_eff + 16'(new_fill);
						rec_off_q <= rec_off_eff + 16'(new_fill);
						fill_q <= '0;
						dsum_q <= '0;
					end else begin
						rec_off_q <= rec_off_eff;
						fill_q <= new_fill;
						dsum_q <= new_dsum;
					end
				end
				ihex_pkg::OpFinish: begin
					fill_q <= '0;
					dsum_q <= '0;
					rec_off_q <= running_q;
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

endmodule

@@ rtl/ihex_fifo.sv @@
// Two-entry command queue between the front end and the back end.
module ihex_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ihex_pkg::ihex_cmd_t   push_cmd,
	output logic                  full,
	input  logic                  pop,
	output logic                  empty,
	output ihex_pkg::ihex_cmd_t   head
);

	ihex_pkg::ihex_cmd_t  mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

@@ rtl/ihex_back.sv @@
// Back end: prints one record command as ASCII characters, one per cycle unless the receiver stalls the output.
module ihex_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  ihex_pkg::ihex_cmd_t   q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [6:0]            out_char,
	output logic                  last_char
);

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_COLON   = 4'b0010,
		ST_HEX     = 4'b0100,
		ST_NEWLINE = 4'b1000
	} back_state_t;

	back_state_t                    state_q;
	ihex_pkg::ihex_cmd_t            cur_q;
	logic [ihex_pkg::ByteIdxW-1:0]  bidx_q;
	logic                           lo_nib_q;
	logic                           out_valid_q;
	logic [6:0]                     out_char_q;
	logic                           last_char_q;

	logic                           step;
	logic [ihex_pkg::ByteIdxW-1:0]  last_idx;
	logic [ihex_pkg::ByteIdxW-1:0]  data_idx;
	logic [7:0]                     sel_byte;
	logic [3:0]                     sel_nib;

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign last_char = last_char_q;

	// The output register may be refilled when empty or being taken.
	assign step = !out_valid_q || out_ready;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	// Select the record byte being printed.
	assign last_idx = ihex_pkg::ByteIdxW'(cur_q.len) + ihex_pkg::ByteIdxW'(ihex_pkg::PosData);
	assign data_idx = bidx_q - ihex_pkg::ByteIdxW'(ihex_pkg::PosData);
	always_comb begin
		case (bidx_q)
			ihex_pkg::ByteIdxW'(ihex_pkg::PosLen):   sel_byte = 8'(cur_q.len);
			ihex_pkg::ByteIdxW'(ihex_pkg::PosOffHi): sel_byte = cur_q.offset[15:8];
			ihex_pkg::ByteIdxW'(ihex_pkg::PosOffLo): sel_byte = cur_q.offset[7:0];
			ihex_pkg::ByteIdxW'(ihex_pkg::PosType):  sel_byte = cur_q.rtype;
			default: begin
				if (bidx_q == last_idx) begin
					sel_byte = cur_q.checksum;
				end else begin
					sel_byte = cur_q.data[data_idx[ihex_pkg::CmdIdxW-1:0]];
				end
			end
		endcase
	end
	assign sel_nib = lo_nib_q ? sel_byte[3:0] : sel_byte[7:4];

	// Character sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bidx_q <= '0;
			lo_nib_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (step) begin
						out_valid_q <= 1'b0;
					end
					if (!q_empty) begin
						state_q <= ST_COLON;
					end
				end
				ST_COLON: begin
					if (step) begin
						out_valid_q <= 1'b1;
						bidx_q <= '0;
						lo_nib_q <= 1'b0;
						state_q <= ST_HEX;
					end
				end
				ST_HEX: begin
					if (step) begin
						out_valid_q <= 1'b1;
						lo_nib_q <= !lo_nib_q;
						if (lo_nib_q) begin
							if (bidx_q == last_idx) begin
								state_q <= ST_NEWLINE;
							end else begin
								bidx_q <= bidx_q + ihex_pkg::ByteIdxW'(1);
							end
						end
					end
				end
				ST_NEWLINE: begin
					if (step) begin
						out_valid_q <= 1'b1;
						state_q <= cur_q.eof_follow ? ST_COLON : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	// Current record and output character payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					cur_q <= q_head;
				end
			end
			ST_COLON: begin
				if (step) begin
					out_char_q <= ihex_pkg::CharColon;
					last_char_q <= 1'b0;
				end
			end
			ST_HEX: begin
				if (step) begin
					out_char_q <= ihex_pkg::hex_char(sel_nib);
					last_char_q <= 1'b0;
				end
			end
			ST_NEWLINE: begin
				if (step) begin
					out_char_q <= ihex_pkg::CharNewline;
					last_char_q <= cur_q.last_rec;
					// An end-of-file record follows the start address record.
					if (cur_q.eof_follow) begin
						cur_q.len <= '0;
						cur_q.offset <= 16'h0000;
						cur_q.rtype <= ihex_pkg::RecEof;
						cur_q.checksum <= ihex_pkg::record_checksum(8'd0, 16'h0000,
							ihex_pkg::RecEof, 8'd0);
						cur_q.last_rec <= 1'b1;
						cur_q.eof_follow <= 1'b0;
					end
				end
			end
			default: begin
				last_char_q <= 1'b0;
			end
		endcase
	end

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the Intel HEX record encoder.
`timescale 1ns / 1ps

module tb;

	// The op code that the encoder ignores.
	localparam logic [1:0] OpReserved = 2'd3;
	// Cycles to watch for stray characters once the text is complete.
	localparam int DrainCycles = 40;
	localparam int MaxReported = 10;

	typedef struct packed {
		logic [6:0] ch;
		logic       is_last;
	} text_char_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [31:0] address;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [6:0]  out_char;
	logic        last_char;

	// Characters still owed by the encoder, oldest first.
	text_char_t expected_text[$];
	int mismatch_count = 0;
	int items_sent = 0;
	bit quiet = 1'b0;
	bit sender_steady = 1'b0;
	int hold_cycles = 0;

	// Shadow of the encoder state.
	logic [ihex_pkg::RecordBytes-1:0][7:0] line_bytes;
	int line_fill;
	logic [15:0] next_offset;
	logic [15:0] line_offset;
	logic [7:0] line_sum;

	intel_hex_record_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.address   (address),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last_char (last_char)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Text prediction.
	task automatic push_text(input logic [6:0] ch);
		text_char_t c;
		c.ch = ch;
		c.is_last = 1'b0;
		expected_text.push_back(c);
	endtask

	task automatic push_hex_byte(input logic [7:0] b);
		logic [3:0] nib;
		for (int k = 1; k >= 0; k--) begin
			nib = b[k*4 +: 4];
			if (nib < 4'd10) begin
				push_text(7'h30 + 7'(nib));
			end else begin
				push_text(7'h41 + 7'(nib - 4'd10));
			end
		end
	endtask

	// One record: colon, length, offset, type, data, checksum, line feed.
	task automatic push_record(input int len, input logic [15:0] offset,
			input logic [7:0] rtype, input logic [ihex_pkg::CmdBytes-1:0][7:0] payload,
			input logic [7:0] dsum);
		logic [7:0] sum;
		sum = 8'(len) + offset[15:8] + offset[7:0] + rtype + dsum;
		push_text(ihex_pkg::CharColon);
		push_hex_byte(8'(len));
		push_hex_byte(offset[15:8]);
		push_hex_byte(offset[7:0]);
		push_hex_byte(rtype);
		for (int i = 0; i < len; i++) begin
			push_hex_byte(payload[i]);
		end
		push_hex_byte(8'h00 - sum);
		push_text(ihex_pkg::CharNewline);
	endtask

	// Works out the text that one accepted item causes and updates the shadow state.
	task automatic encode_item(input logic [1:0] item_op, input logic [31:0] addr,
			input logic [7:0] b, input logic is_final);
		logic [ihex_pkg::CmdBytes-1:0][7:0] hdr;
		int start_size;
		start_size = expected_text.size();
		hdr = '0;
		case (item_op)
			ihex_pkg::OpBegin: begin
				hdr[0] = addr[31:24];
				hdr[1] = addr[23:16];
				push_record(2, 16'h0000, ihex_pkg::RecExtLinear, hdr,
					addr[31:24] + addr[23:16]);
				next_offset = addr[15:0];
				line_offset = next_offset;
				line_fill = 0;
				line_sum = 8'h00;
			end
			ihex_pkg::OpData: begin
				if (line_fill == 0) begin
					line_offset = next_offset;
				end
				if (line_fill < ihex_pkg::RecordBytes) begin
					line_bytes[line_fill] = b;
					line_fill++;
					line_sum = line_sum + b;
				end
				if (line_fill >= ihex_pkg::RecordBytes || is_final) begin
					push_record(line_fill, line_offset, ihex_pkg::RecData,
						line_bytes, line_sum);
					next_offset = line_offset + 16'(line_fill);
					line_offset = next_offset;
					line_fill = 0;
					line_sum = 8'h00;
				end
			end
			ihex_pkg::OpFinish: begin
				hdr[0] = addr[31:24];
				hdr[1] = addr[23:16];
				hdr[2] = addr[15:8];
				hdr[3] = addr[7:0];
				push_record(4, 16'h0000, ihex_pkg::RecStartLinear, hdr,
					addr[31:24] + addr[23:16] + addr[15:8] + addr[7:0]);
				push_record(0, 16'h0000, ihex_pkg::RecEof, hdr, 8'h00);
				line_fill = 0;
				line_sum = 8'h00;
				line_offset = next_offset;
			end
			default: begin
			end
		endcase
		// The final character of this item carries the end flag.
		if (expected_text.size() > start_size) begin
			expected_text[expected_text.size() - 1].is_last = 1'b1;
		end
	endtask

	// Sends one item, idling first at random, and predicts its text on transfer.
	task automatic send_item(input logic [1:0] item_op, input logic [31:0] addr,
			input logic [7:0] b, input logic is_final);
		if (!quiet && !sender_steady && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= item_op;
		address <= addr;
		data_byte <= b;
		last_byte <= is_final;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		encode_item(item_op, addr, b, is_final);
		if (item_op != OpReserved) begin
			items_sent++;
		end
	endtask

	task automatic report_mismatch(input string what, input int expv, input int actv);
		mismatch_count++;
		if (mismatch_count <= MaxReported) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, expv, actv);
		end
	endtask

	// Each character transfer is checked against the oldest owed character.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_text.size() == 0) begin
				report_mismatch("unexpected character", 0, out_char);
			end else begin
				want = expected_text.pop_front();
				if (out_char !== want.ch) begin
					report_mismatch("out_char", want.ch, out_char);
				end
				if (last_char !== want.is_last) begin
					report_mismatch("last_char", want.is_last, last_char);
				end
			end
		end
	end

	// Receiver: random stall bursts, calm stretches, and the long hold-off on request.
	initial begin
		int stall_left;
		int calm_left;
		stall_left = 0;
		calm_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (quiet || calm_left > 0) begin
				out_ready <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end
			end else begin
				case ($urandom_range(0, 15))
					0, 1: begin
						stall_left = $urandom_range(1, 18) - 1;
						out_ready <= 1'b0;
					end
					2: begin
						calm_left = $urandom_range(20, 80);
						out_ready <= 1'b1;
					end
					default: out_ready <= 1'b1;
				endcase
			end
		end
	end

	// Extended address records at both ends of the address range, empty segments.
	task automatic test_segment_headers();
		send_item(ihex_pkg::OpBegin, 32'h0000_0000, 8'h00, 1'b0);
		send_item(ihex_pkg::OpBegin, 32'hFFFF_FFFF, 8'hFF, 1'b1);
	endtask

	// A short record at offset FFFF, after which the offset wraps.
	task automatic test_offset_wrap();
		send_item(ihex_pkg::OpData, 32'hFFFF_FFFF, 8'h00, 1'b0);
		send_item(ihex_pkg::OpData, 32'h0000_0000, 8'hFF, 1'b1);
	endtask

	// A begin or a finish with bytes buffered drops them.
	task automatic test_dropped_bytes();
		send_item(ihex_pkg::OpData, 32'h0000_0000, 8'hAA, 1'b0);
		send_item(ihex_pkg::OpBegin, 32'h1234_5678, 8'h00, 1'b1);
		send_item(ihex_pkg::OpData, 32'h0000_0000, 8'h55, 1'b0);
		send_item(ihex_pkg::OpFinish, 32'hFFFF_FFFF, 8'h00, 1'b1);
	endtask

	task automatic test_finish_records();
		send_item(ihex_pkg::OpFinish, 32'h0000_0000, 8'hFF, 1'b0);
	endtask

	task automatic test_reserved_op();
		send_item(OpReserved, $urandom(), 8'($urandom()), 1'($urandom()));
	endtask

	// Sixteen bytes fill a record without any end mark.
	task automatic test_full_record();
		for (int i = 0; i < ihex_pkg::RecordBytes; i++) begin
			send_item(ihex_pkg::OpData, 32'h0000_0000, 8'($urandom()), 1'b0);
		end
	endtask

	// The receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_backpressure();
		sender_steady = 1'b1;
		hold_cycles = 300;
		send_item(ihex_pkg::OpBegin, $urandom(), 8'h00, 1'b0);
		for (int i = 0; i < 40; i++) begin
			send_item(ihex_pkg::OpData, 32'h0000_0000, 8'($urandom()), i == 39);
		end
		sender_steady = 1'b0;
	endtask

	// Mostly well-formed segments with random content, mixed with noise.
	task automatic test_random_stream();
		int start_count;
		int seg_len;
		logic [31:0] base;
		bit mark_end;
		start_count = items_sent;
		while (items_sent - start_count < 50) begin
			case ($urandom_range(0, 9))
				7: send_item(OpReserved, $urandom(), 8'($urandom()), 1'($urandom()));
				8: begin
					seg_len = $urandom_range(1, 5);
					for (int i = 0; i < seg_len; i++) begin
						send_item(ihex_pkg::OpData, $urandom(), 8'($urandom()),
							1'($urandom()));
					end
				end
				9: send_item(ihex_pkg::OpFinish, $urandom(), 8'($urandom()),
					1'($urandom()));
				default: begin
					base = $urandom();
					// Some segments start close to the top of the offset space.
					if ($urandom_range(0, 3) == 0) begin
						base[15:0] = 16'hFFFF - 16'($urandom_range(0, 40));
					end
					seg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 48)
						: $urandom_range(1, 20);
					mark_end = ($urandom_range(0, 5) != 0);
					send_item(ihex_pkg::OpBegin, base, 8'($urandom()), 1'($urandom()));
					for (int i = 0; i < seg_len; i++) begin
						send_item(ihex_pkg::OpData, $urandom(), 8'($urandom()),
							mark_end && i == seg_len - 1);
					end
				end
			endcase
		end
	endtask

	// Last segment and finish with no idling on either side.
	task automatic test_quiet_tail();
		quiet = 1'b1;
		send_item(ihex_pkg::OpBegin, $urandom(), 8'h00, 1'b0);
		for (int i = 0; i < 33; i++) begin
			send_item(ihex_pkg::OpData, $urandom(), 8'($urandom()), i == 32);
		end
		send_item(ihex_pkg::OpFinish, $urandom(), 8'h00, 1'b0);
	endtask

	initial begin
		in_valid = 1'b0;
		op = ihex_pkg::OpBegin;
		address = 32'h0000_0000;
		data_byte = 8'h00;
		last_byte = 1'b0;
		arst_n = 1'b0;
		line_bytes = '0;
		line_fill = 0;
		next_offset = 16'h0000;
		line_offset = 16'h0000;
		line_sum = 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_segment_headers();
		test_offset_wrap();
		test_dropped_bytes();
		test_finish_records();
		test_reserved_op();
		test_full_record();
		test_backpressure();
		test_random_stream();
		test_quiet_tail();

		// Let the owed text drain, then watch for stray characters.
		in_valid <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("intel_hex_record_encoder verification clean");
		end else begin
			$display("intel_hex_record_encoder verification failed");
		end
		$finish;
	end

	// Timeout.
	initial begin
		#2000000;
		$display("intel_hex_record_encoder verification failed");
		$finish;
	end

endmodule
